[design/spn_pkg.sv]
// shared types, s-box and bit permutation tables for the spn block encryptor
`timescale 1ns / 1ps

package spn_pkg;

  // block and key stream widths
  localparam int unsigned BLOCK_W = 128;
  localparam int unsigned KEY_W   = 64;
  localparam int unsigned KSTR_W  = 3 * KEY_W;

  // configuration register indexes
  typedef enum logic [1:0] {
    KEY_REG_0   = 2'd0,
    KEY_REG_1   = 2'd1,
    KEY_REG_2   = 2'd2,
    KEY_REG_NONE = 2'd3
  } key_reg_e;

  // one pipeline stage: valid bit travels with the block
  typedef struct packed {
    logic               valid;
    logic [BLOCK_W-1:0] data;
  } spn_stage_t;

  // aes forward s-box
  localparam logic [7:0] SBOX_TABLE [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  // new bit g (0 = msb) takes old bit PERM_TABLE[g]
  localparam logic [6:0] PERM_TABLE [128] = '{
    7'd41,  7'd35,  7'd62,  7'd97,  7'd108, 7'd86,  7'd46,  7'd82,
    7'd16,  7'd73,  7'd113, 7'd59,  7'd105, 7'd107, 7'd51,  7'd38,
    7'd91,  7'd60,  7'd7,   7'd12,  7'd25,  7'd94,  7'd13,  7'd28,
    7'd55,  7'd71,  7'd18,  7'd77,  7'd72,  7'd67,  7'd11,  7'd31,
    7'd3,   7'd90,  7'd125, 7'd56,  7'd37,  7'd93,  7'd84,  7'd75,
    7'd124, 7'd22,  7'd117, 7'd69,  7'd19,  7'd10,  7'd50,  7'd32,
    7'd26,  7'd80,  7'd110, 7'd64,  7'd120, 7'd54,  7'd118, 7'd30,
    7'd92,  7'd45,  7'd79,  7'd20,  7'd114, 7'd68,  7'd102, 7'd48,
    7'd33,  7'd34,  7'd17,  7'd29,  7'd74,  7'd2,   7'd57,  7'd44,
    7'd126, 7'd85,  7'd106, 7'd76,  7'd83,  7'd63,  7'd103, 7'd14,
    7'd111, 7'd87,  7'd127, 7'd15,  7'd81,  7'd112, 7'd119, 7'd104,
    7'd116, 7'd89,  7'd53,  7'd42,  7'd101, 7'd43,  7'd1,   7'd95,
    7'd123, 7'd5,   7'd21,  7'd24,  7'd100, 7'd78,  7'd49,  7'd70,
    7'd4,   7'd115, 7'd47,  7'd122, 7'd36,  7'd8,   7'd121, 7'd88,
    7'd40,  7'd96,  7'd61,  7'd23,  7'd39,  7'd66,  7'd65,  7'd27,
    7'd6,   7'd98,  7'd52,  7'd9,   7'd99,  7'd109, 7'd58,  7'd0
  };

  // 128-bit key window starting at stream bit off (stream bit 0 is the msb)
  function automatic logic [BLOCK_W-1:0] key_window(input logic [KSTR_W-1:0] kstr,
                                                    input int unsigned off);
    logic [KSTR_W-1:0] shifted;
    shifted = kstr << off;
    return shifted[KSTR_W-1 -: BLOCK_W];
  endfunction

endpackage

[design/spn_block_encrypt_128_core.sv]
// top level: whitening stage, unrolled round pipeline and output key mix
// path: a request passes the whitening register, the round registers and the output register in that order
// throughput: one block per cycle while the output is not held; one register stage per round (one s-box layer deep)
// stall: the whole pipeline holds while the output request waits for out_ready_i
// reset: clears all stage valid bits and the three key registers to zero
`timescale 1ns / 1ps

module spn_block_encrypt_128_core
  import spn_pkg::*;
#(
  parameter int unsigned ROUND_COUNT = 15
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [KEY_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [KEY_W-1:0] plain_high_i,
  input  logic [KEY_W-1:0] plain_low_i,
  input  logic [KEY_W-1:0] chain_high_i,
  input  logic [KEY_W-1:0] chain_low_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [KEY_W-1:0] cipher_high_o,
  output logic [KEY_W-1:0] cipher_low_o
);

  logic [KSTR_W-1:0]  kstr;
  logic               en;
  logic               in_valid_q;
  logic [BLOCK_W-1:0] in_data_q;
  logic               out_valid_q;
  logic [BLOCK_W-1:0] out_data_q;
  spn_stage_t         stage [ROUND_COUNT+1];

  // key registers
  spn_key_store u_key_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .kstr_o     (kstr)
  );

  // pipeline advances unless a finished block is held at the output
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // whitening stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (en) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_data_q <= {plain_high_i ^ chain_high_i, plain_low_i ^ chain_low_i};
    end
  end

  assign stage[0] = '{valid: in_valid_q, data: in_data_q};

  // round stages
  for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
    spn_round #(
      .ROUND_IDX  (r),
      .LAST_ROUND (r == ROUND_COUNT - 1)
    ) u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .stage_i (stage[r]),
      .kstr_i  (kstr),
      .stage_o (stage[r+1])
    );
  end

  // output stage with final key mix
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= stage[ROUND_COUNT].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= stage[ROUND_COUNT].data ^ key_window(kstr, 4 * ROUND_COUNT);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign cipher_high_o = out_data_q[BLOCK_W-1 -: KEY_W];
  assign cipher_low_o  = out_data_q[KEY_W-1:0];

  // an accepted request shows up in the whitening stage
  a_in_to_stage0 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> in_valid_q)
    else $error("accepted request missing from first stage");

  // a held output freezes the last round stage and the whitening stage
  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(stage[ROUND_COUNT].valid) && $stable(stage[0].valid))
    else $error("pipeline moved during a stall");

  // output request only appears after a valid last round
  a_out_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(stage[ROUND_COUNT].valid))
    else $error("output request without a finished round");

endmodule

[design/spn_key_store.sv]
// key stream registers written through the configuration port
`timescale 1ns / 1ps

module spn_key_store
  import spn_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [KEY_W-1:0]  cfg_data_i,
  output logic [KSTR_W-1:0] kstr_o
);

  logic [KEY_W-1:0] key0_q, key1_q, key2_q;
  key_reg_e         idx;

  assign idx = key_reg_e'(cfg_idx_i);

  // register write decode, unused index is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key0_q <= '0;
      key1_q <= '0;
      key2_q <= '0;
    end else if (cfg_we_i) begin
      unique case (idx)
        KEY_REG_0: key0_q <= cfg_data_i;
        KEY_REG_1: key1_q <= cfg_data_i;
        KEY_REG_2: key2_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stream bit 0 lands in the msb
  assign kstr_o = {key0_q, key1_q, key2_q};

endmodule

[design/spn_round.sv]
// one registered round: key mix, byte substitution and optional bit permutation
`timescale 1ns / 1ps

module spn_round
  import spn_pkg::*;
#(
  parameter int unsigned ROUND_IDX  = 0,
  parameter bit          LAST_ROUND = 1'b0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  spn_stage_t        stage_i,
  input  logic [KSTR_W-1:0] kstr_i,
  output spn_stage_t        stage_o
);

  logic [BLOCK_W-1:0] mixed;
  logic [BLOCK_W-1:0] subst;
  logic [BLOCK_W-1:0] permed;
  logic               valid_q;
  logic [BLOCK_W-1:0] data_q;

  // round key window
  assign mixed = stage_i.data ^ key_window(kstr_i, 4 * ROUND_IDX);

  // s-box on each byte
  always_comb begin
    for (int b = 0; b < BLOCK_W / 8; b++) begin
      subst[8*b +: 8] = SBOX_TABLE[mixed[8*b +: 8]];
    end
  end

  // fixed wiring permutation, skipped in the last round
  always_comb begin
    for (int g = 0; g < BLOCK_W; g++) begin
      permed[BLOCK_W-1-g] = subst[BLOCK_W-1-int'(PERM_TABLE[g])];
    end
  end

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= stage_i.valid;
    end
  end

  // stage data
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= LAST_ROUND ? subst : permed;
    end
  end

  assign stage_o = '{valid: valid_q, data: data_q};

endmodule
